[src/wsvs_pkg.sv]
`timescale 1ns / 1ps
package wsvs_pkg;

  localparam int WAVE_LENGTH = 512;
  localparam int STEPS       = 16;
  localparam int SUBTABLES   = 9;
  localparam int STEP_W      = 4;
  localparam int NOTE_W      = 6;
  localparam int TABLE_SEL_W = 3;

  localparam logic [31:0] FULL_SCALE  = 32'hFFFF_FFFF;
  localparam logic [31:0] BLEND_CLAMP = 32'hE000_0000;
  localparam logic [7:0]  FADE_FULL   = 8'hFF;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WAVE  = 2'd1,
    MODE_PITCH = 2'd2,
    MODE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_BLEND_POSITION  = 3'd0,
    CFG_SHAPE_AMOUNT    = 3'd1,
    CFG_AMP_RISE_STEP   = 3'd2,
    CFG_AMP_FALL_STEP   = 3'd3,
    CFG_SHAPE_RISE_STEP = 3'd4,
    CFG_SHAPE_FALL_STEP = 3'd5,
    CFG_TEMPO_INCREMENT = 3'd6,
    CFG_TABLE_SELECT    = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              on;
  } step_entry_t;

endpackage

[src/wavetable_synth_voice_sequencer_unit.sv]
`timescale 1ns / 1ps
// Wavetable voice with a 16-step sequencer. Write items (tuser mode wave, pitch or step)
// load the stores and give no result. A tick item gives one output item and runs through
// the shape multiply, the blend and wave address with the step and pitch reads, then two
// reads through the one read port of the wave memory at the two adjacent sub-tables, each
// feeding one crossfade multiply, and a final amp multiply into the output register. The
// last of these steps is held for as long as the output register is still full. The block
// takes one item at a time; a new item is accepted while the previous result still waits
// in the output register. Configuration is written through cfg_we/cfg_index/cfg_data by
// the user, only while idle; the block does not enforce it. A zero tempo increment pauses
// the sequencer. Wave and pitch entries must be written before a tick reads them.
module wavetable_synth_voice_sequencer_unit #(
  parameter int WAVE_TABLES = 4,
  parameter int NOTES       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // address[14:0], word_value[46:15], step_note[52:47],
                                 // step_enabled[53], zero[55:54]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // dac_code[11:0], active_step[15:12], step_advanced[16],
                                 // zero[23:17]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TABLE_WORDS = wsvs_pkg::SUBTABLES * wsvs_pkg::WAVE_LENGTH;
  localparam int WAVE_DEPTH  = WAVE_TABLES * TABLE_WORDS;
  localparam int WAVE_AW     = $clog2(WAVE_DEPTH);
  localparam int PITCH_AW    = $clog2(NOTES);

  typedef enum logic [2:0] {S_IDLE, S_POS, S_RD2, S_MIX, S_OUT} state_t;

  state_t state;

  // configuration
  logic [31:0] blend_position, amp_rise_step, amp_fall_step;
  logic [31:0] shape_rise_step, shape_fall_step, tempo_increment;
  logic [7:0]  shape_amount;
  logic [wsvs_pkg::TABLE_SEL_W-1:0] table_sel;
  logic [3:0]  ts_mod;

  // voice state
  logic [31:0] osc_phase, sequence_phase, amp_level, shape_level;
  logic [wsvs_pkg::STEP_W-1:0] current_step;
  logic        amp_attack_flag, shape_attack_flag;

  // work registers
  logic [31:0] shape_add, seq_next, p1;
  logic [32:0] mix;
  logic [7:0]  fade;
  logic [15:0] wave_addr1;
  logic        note_ok, step_on;

  // input fields
  wsvs_pkg::mode_t in_mode;
  logic [14:0] in_address;
  logic [31:0] in_word;
  logic [wsvs_pkg::NOTE_W-1:0] in_note;
  logic        in_enabled;
  logic        s_acc, tick_acc, out_load;

  assign in_mode    = wsvs_pkg::mode_t'(s_tuser);
  assign in_address = s_tdata[14:0];
  assign in_word    = s_tdata[46:15];
  assign in_note    = s_tdata[52:47];
  assign in_enabled = s_tdata[53];

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign tick_acc = s_acc && (in_mode == wsvs_pkg::MODE_TICK);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // memories
  logic               wave_we, wave_re;
  logic [WAVE_AW-1:0] wave_raddr;
  logic [31:0]        wave_rdata;
  logic               pitch_we;
  logic [31:0]        pitch_rdata;
  logic               step_we, step_re;
  logic [wsvs_pkg::STEP_W-1:0] step_raddr;
  wsvs_pkg::step_entry_t step_wdata, step_rdata;

  // blend position and wave address
  logic [31:0] room, add_sat, pos_sum;
  logic [15:0] table_base, addr1_comb;

  assign room       = ~blend_position;
  assign add_sat    = (shape_add > room) ? room : shape_add;
  assign pos_sum    = blend_position + add_sat;
  assign table_base = (16'(table_sel) << 12) + (16'(table_sel) << 9);
  assign addr1_comb = table_base + 16'({pos_sum[31:29], osc_phase[31:23]});

  assign wave_we    = s_acc && (in_mode == wsvs_pkg::MODE_WAVE)
                      && (17'(in_address) < 17'(WAVE_DEPTH));
  assign wave_re    = (state == S_POS) || (state == S_RD2);
  assign wave_raddr = (state == S_POS) ? WAVE_AW'(addr1_comb)
                                       : WAVE_AW'(wave_addr1 + 16'(wsvs_pkg::WAVE_LENGTH));

  assign pitch_we   = s_acc && (in_mode == wsvs_pkg::MODE_PITCH)
                      && (in_address < 15'(NOTES));

  assign step_we         = s_acc && (in_mode == wsvs_pkg::MODE_STEP)
                           && (in_address < 15'(wsvs_pkg::STEPS));
  assign step_wdata.note = in_note;
  assign step_wdata.on   = in_enabled;
  assign step_re         = tick_acc || (state == S_POS);
  assign step_raddr      = (state == S_POS) ? seq_next[31:28] : current_step;

  wsvs_ram #(.DEPTH(WAVE_DEPTH), .WIDTH(32)) u_wave (
    .clk   (clk),
    .we    (wave_we),
    .waddr (WAVE_AW'(in_address)),
    .wdata (in_word),
    .re    (wave_re),
    .raddr (wave_raddr),
    .rdata (wave_rdata)
  );

  wsvs_ram #(.DEPTH(NOTES), .WIDTH(32)) u_pitch (
    .clk   (clk),
    .we    (pitch_we),
    .waddr (PITCH_AW'(in_address)),
    .wdata (in_word),
    .re    (state == S_POS),
    .raddr (PITCH_AW'(step_rdata.note)),
    .rdata (pitch_rdata)
  );

  wsvs_step_mem u_step (
    .clk   (clk),
    .rst   (rst),
    .we    (step_we),
    .waddr (in_address[wsvs_pkg::STEP_W-1:0]),
    .wdata (step_wdata),
    .re    (step_re),
    .raddr (step_raddr),
    .rdata (step_rdata)
  );

  // table select takes the low two bits of cfg_data, wrapped modulo the table count
  always_comb begin
    ts_mod = 4'(cfg_data[1:0]);
    for (int k = 0; k < 3; k++) begin
      if (ts_mod >= 4'(WAVE_TABLES)) begin
        ts_mod = ts_mod - 4'(WAVE_TABLES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_position  <= '0;
      shape_amount    <= '0;
      amp_rise_step   <= '0;
      amp_fall_step   <= '0;
      shape_rise_step <= '0;
      shape_fall_step <= '0;
      tempo_increment <= '0;
      table_sel       <= '0;
    end else if (cfg_we) begin
      unique case (wsvs_pkg::cfg_index_t'(cfg_index))
        wsvs_pkg::CFG_BLEND_POSITION: begin
          blend_position <= (cfg_data[31:29] == 3'b111) ? wsvs_pkg::BLEND_CLAMP : cfg_data;
        end
        wsvs_pkg::CFG_SHAPE_AMOUNT:    shape_amount    <= cfg_data[7:0];
        wsvs_pkg::CFG_AMP_RISE_STEP:   amp_rise_step   <= cfg_data;
        wsvs_pkg::CFG_AMP_FALL_STEP:   amp_fall_step   <= cfg_data;
        wsvs_pkg::CFG_SHAPE_RISE_STEP: shape_rise_step <= cfg_data;
        wsvs_pkg::CFG_SHAPE_FALL_STEP: shape_fall_step <= cfg_data;
        wsvs_pkg::CFG_TEMPO_INCREMENT: tempo_increment <= cfg_data;
        wsvs_pkg::CFG_TABLE_SELECT:    table_sel <= ts_mod[wsvs_pkg::TABLE_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // envelope step: {rising_next, level_next}
  function automatic logic [32:0] env_next(input logic [31:0] level, input logic rising,
                                           input logic [31:0] up, input logic [31:0] down);
    logic [31:0] lvl;
    logic        r;
    lvl = level;
    r   = rising;
    if (rising) begin
      lvl = ((~level) < up) ? wsvs_pkg::FULL_SCALE : level + up;
      r   = (lvl != wsvs_pkg::FULL_SCALE);
    end else begin
      lvl = (level < down) ? 32'd0 : level - down;
    end
    return {r, lvl};
  endfunction

  logic [32:0] amp_env, shape_upd, scaled;
  logic [wsvs_pkg::STEP_W-1:0] new_step;
  logic        moved;

  assign amp_env   = env_next(amp_level, amp_attack_flag, amp_rise_step, amp_fall_step);
  assign shape_upd = env_next(shape_level, shape_attack_flag, shape_rise_step, shape_fall_step);
  assign new_step  = seq_next[31:28];
  assign moved     = (new_step != current_step);
  assign scaled    = 33'(mix[32:8]) * 33'(amp_level[31:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      m_tvalid          <= 1'b0;
      osc_phase         <= '0;
      sequence_phase    <= '0;
      current_step      <= '0;
      amp_level         <= '0;
      shape_level       <= '0;
      amp_attack_flag   <= 1'b0;
      shape_attack_flag <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_acc) begin
            shape_add <= 32'(shape_level[31:8]) * 32'(shape_amount);
            seq_next  <= sequence_phase + tempo_increment;
            state     <= S_POS;
          end
        end
        S_POS: begin
          fade       <= pos_sum[28:21];
          wave_addr1 <= addr1_comb;
          note_ok    <= (7'(step_rdata.note) < 7'(NOTES));
          state      <= S_RD2;
        end
        S_RD2: begin
          p1        <= 32'(wsvs_pkg::FADE_FULL - fade) * 32'(wave_rdata[31:8]);
          osc_phase <= osc_phase + (note_ok ? pitch_rdata : 32'd0);
          step_on   <= step_rdata.on;
          state     <= S_MIX;
        end
        S_MIX: begin
          mix   <= 33'(p1) + 33'(32'(fade) * 32'(wave_rdata[31:8]));
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata           <= {7'd0, moved, new_step, scaled[31:20]};
            sequence_phase    <= seq_next;
            current_step      <= new_step;
            amp_level         <= amp_env[31:0];
            shape_level       <= shape_upd[31:0];
            amp_attack_flag   <= moved ? step_on : amp_env[32];
            shape_attack_flag <= moved ? step_on : shape_upd[32];
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tick_reaches_out: assert property (@(posedge clk) disable iff (rst)
    tick_acc |-> ##4 (state == S_OUT))
    else $error("tick did not reach output stage");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("output valid raised outside output stage");

  a_advance_flag: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tdata[16] == (current_step != $past(current_step))))
    else $error("step_advanced does not match step change");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(wave_we || pitch_we || step_we))
    else $error("store written during a tick");

endmodule

[src/wsvs_ram.sv]
`timescale 1ns / 1ps
module wsvs_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/wsvs_step_mem.sv]
`timescale 1ns / 1ps
module wsvs_step_mem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [wsvs_pkg::STEP_W-1:0]       waddr,
  input  wsvs_pkg::step_entry_t             wdata,
  input  logic                              re,
  input  logic [wsvs_pkg::STEP_W-1:0]       raddr,
  output wsvs_pkg::step_entry_t             rdata
);

  wsvs_pkg::step_entry_t mem [wsvs_pkg::STEPS];
  logic [wsvs_pkg::STEPS-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

endmodule

[test/wavetable_synth_voice_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
module wavetable_synth_voice_sequencer_unit_tb;

  localparam int WAVE_TABLES = 4;
  localparam int NOTES       = 64;
  localparam int TABLE_WORDS = wsvs_pkg::SUBTABLES * wsvs_pkg::WAVE_LENGTH;
  localparam int WAVE_DEPTH  = WAVE_TABLES * TABLE_WORDS;

  typedef struct packed {
    wsvs_pkg::mode_t mode;
    logic [14:0] addr;
    logic [31:0] word;
    logic [5:0]  note;
    logic        step_on;
  } voice_item_t;

  typedef struct packed {
    logic [11:0] dac;
    logic [3:0]  step;
    logic        advanced;
  } voice_out_t;

  typedef struct packed {
    bit          is_reg;
    wsvs_pkg::cfg_index_t reg_idx;
    logic [31:0] reg_val;
    voice_item_t item;
    bit          typed;
    voice_out_t  want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // address, word_value, step_note, step_enabled, zero pad
  logic [1:0]  s_tuser = '0;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // dac_code, active_step, step_advanced, zero pad
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  wavetable_synth_voice_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // voice model state
  bit [31:0] blend_pos, shp_amount, amp_up, amp_down, shp_up, shp_down, tempo_inc;
  bit [1:0]  table_sel;
  bit [31:0] ph_osc, ph_seq, amp_env, shp_env;
  bit [3:0]  cur_step;
  bit        amp_attack, shp_attack;
  bit [31:0] wave_mem [WAVE_DEPTH];
  bit        wave_known [WAVE_DEPTH];
  bit [31:0] pitch_mem [NOTES];
  bit        pitch_known [NOTES];
  bit [5:0]  step_note_mem [wsvs_pkg::STEPS];
  bit        step_on_mem [wsvs_pkg::STEPS];

  voice_out_t pending_samples[$];
  voice_out_t got_expect;
  plan_row_t  demo_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int reg_writes = 0;
  bit calm = 1'b0;
  bit held_off = 1'b0;

  initial forever #1 clk = ~clk;

  // timeout
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic log_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic env_advance(inout bit [31:0] lvl, inout bit rising,
                             input bit [31:0] up, input bit [31:0] down);
    if (rising) begin
      lvl = (wsvs_pkg::FULL_SCALE - lvl < up) ? wsvs_pkg::FULL_SCALE : lvl + up;
      if (lvl == wsvs_pkg::FULL_SCALE) rising = 1'b0;
    end else begin
      lvl = (lvl < down) ? 32'd0 : lvl - down;
    end
  endtask

  // first of the two wave words the next sample reads
  function automatic int wave_read_addr(output bit [7:0] fade);
    bit [31:0] boost, room, pos;
    boost = {8'd0, shp_env[31:8]} * shp_amount;
    room = wsvs_pkg::FULL_SCALE - blend_pos;
    if (boost > room) boost = room;
    pos = (blend_pos + boost) >> 21;
    fade = pos[7:0];
    return (table_sel % WAVE_TABLES) * TABLE_WORDS + pos[10:8] * wsvs_pkg::WAVE_LENGTH
           + ph_osc[31:23];
  endfunction

  task automatic voice_predict(input voice_item_t it, output bit made, output voice_out_t res);
    int i1;
    bit [7:0] fade;
    bit [63:0] w1, w2, f1, f2, mix, amp_top, scaled;
    bit [3:0] prev;
    bit [5:0] nt;
    made = 1'b0;
    res = '0;
    case (it.mode)
      wsvs_pkg::MODE_WAVE: if (it.addr < WAVE_DEPTH) begin
        wave_mem[it.addr] = it.word;
        wave_known[it.addr] = 1'b1;
      end
      wsvs_pkg::MODE_PITCH: if (it.addr < NOTES) begin
        pitch_mem[it.addr] = it.word;
        pitch_known[it.addr] = 1'b1;
      end
      wsvs_pkg::MODE_STEP: if (it.addr < wsvs_pkg::STEPS) begin
        step_note_mem[it.addr] = it.note;
        step_on_mem[it.addr] = it.step_on;
      end
      wsvs_pkg::MODE_TICK: begin
        i1 = wave_read_addr(fade);
        w1 = wave_mem[i1][31:8];
        w2 = wave_mem[i1 + wsvs_pkg::WAVE_LENGTH][31:8];
        f1 = wsvs_pkg::FADE_FULL - fade;
        f2 = fade;
        mix = f1 * w1 + f2 * w2;
        amp_top = amp_env[31:24];
        scaled = (mix >> 8) * amp_top;
        nt = step_note_mem[cur_step];
        ph_osc += pitch_mem[nt];
        prev = cur_step;
        ph_seq += tempo_inc;
        cur_step = ph_seq[31:28];
        env_advance(amp_env, amp_attack, amp_up, amp_down);
        env_advance(shp_env, shp_attack, shp_up, shp_down);
        if (prev != cur_step) begin
          amp_attack = step_on_mem[cur_step];
          shp_attack = amp_attack;
        end
        res.dac = scaled[31:20];
        res.step = cur_step;
        res.advanced = (prev != cur_step);
        made = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic push_item(voice_item_t it, bit typed, voice_out_t want);
    bit made;
    voice_out_t res;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, it.step_on, it.note, it.word, it.addr};
    s_tuser <= it.mode;
    do @(posedge clk); while (s_tready !== 1'b1);
    voice_predict(it, made, res);
    items_sent++;
    if (made) begin
      ticks_sent++;
      pending_samples.push_back(typed ? want : res);
    end
  endtask

  // a tick first gets the wave words and pitch entry it will read written
  task automatic play(voice_item_t it, bit typed, voice_out_t want);
    int i1;
    bit [7:0] fade;
    bit [5:0] nt;
    voice_item_t fix;
    if (it.mode == wsvs_pkg::MODE_TICK) begin
      i1 = wave_read_addr(fade);
      for (int k = 0; k < 2; k++) begin
        if (!wave_known[i1 + k * wsvs_pkg::WAVE_LENGTH]) begin
          fix = '{wsvs_pkg::MODE_WAVE, 15'(i1 + k * wsvs_pkg::WAVE_LENGTH), $urandom,
                  6'($urandom), 1'($urandom)};
          push_item(fix, 1'b0, '0);
        end
      end
      nt = step_note_mem[cur_step];
      if (!pitch_known[nt]) begin
        fix = '{wsvs_pkg::MODE_PITCH, 15'(nt), $urandom, 6'($urandom), 1'($urandom)};
        push_item(fix, 1'b0, '0);
      end
    end
    push_item(it, typed, want);
  endtask

  task automatic drain_voice();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_register(wsvs_pkg::cfg_index_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      wsvs_pkg::CFG_BLEND_POSITION:
        blend_pos = (v[31:29] > 3'd6) ? wsvs_pkg::BLEND_CLAMP : v;
      wsvs_pkg::CFG_SHAPE_AMOUNT:    shp_amount = {24'd0, v[7:0]};
      wsvs_pkg::CFG_AMP_RISE_STEP:   amp_up = v;
      wsvs_pkg::CFG_AMP_FALL_STEP:   amp_down = v;
      wsvs_pkg::CFG_SHAPE_RISE_STEP: shp_up = v;
      wsvs_pkg::CFG_SHAPE_FALL_STEP: shp_down = v;
      wsvs_pkg::CFG_TEMPO_INCREMENT: tempo_inc = v;
      wsvs_pkg::CFG_TABLE_SELECT:    table_sel = v[1:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_register_value(wsvs_pkg::cfg_index_t idx, int style);
    int r;
    r = $urandom_range(9);
    if (style == 0 || (style == 2 && r == 0)) return 32'd0;
    if (style == 1 || (style == 2 && r == 1)) return wsvs_pkg::FULL_SCALE;
    case (idx)
      wsvs_pkg::CFG_TEMPO_INCREMENT:
        return (r == 2) ? $urandom : $urandom_range(32'h1800_0000, 32'h0200_0000);
      wsvs_pkg::CFG_AMP_RISE_STEP, wsvs_pkg::CFG_AMP_FALL_STEP,
      wsvs_pkg::CFG_SHAPE_RISE_STEP, wsvs_pkg::CFG_SHAPE_FALL_STEP:
        return $urandom >> $urandom_range(12, 0);
      default: return $urandom;
    endcase
  endfunction

  function automatic voice_item_t random_item();
    voice_item_t it;
    int r;
    r = $urandom_range(99);
    it.addr = 15'($urandom);
    it.note = ($urandom_range(99) < 85) ? 6'($urandom_range(48, 0)) : 6'($urandom_range(63, 49));
    it.step_on = ($urandom_range(99) < 70);
    case ($urandom_range(19))
      0: it.word = 32'd0;
      1: it.word = wsvs_pkg::FULL_SCALE;
      default: it.word = $urandom;
    endcase
    if (r < 55) begin
      it.mode = wsvs_pkg::MODE_TICK;
    end else if (r < 75) begin
      it.mode = wsvs_pkg::MODE_WAVE;
      if ($urandom_range(9) != 0) it.addr = 15'($urandom_range(WAVE_DEPTH - 1, 0));
    end else if (r < 85) begin
      it.mode = wsvs_pkg::MODE_PITCH;
      if ($urandom_range(99) < 85) it.addr = 15'($urandom_range(NOTES - 1, 0));
    end else begin
      it.mode = wsvs_pkg::MODE_STEP;
      if ($urandom_range(99) < 85) it.addr = 15'($urandom_range(wsvs_pkg::STEPS - 1, 0));
    end
    return it;
  endfunction

  task automatic add_item(wsvs_pkg::mode_t m, logic [14:0] a, logic [31:0] w, logic [5:0] n,
                          logic e);
    plan_row_t row;
    row = '0;
    row.item = '{m, a, w, n, e};
    demo_rows.push_back(row);
  endtask

  task automatic add_typed_tick(logic [11:0] dac, logic [3:0] step, logic advanced);
    plan_row_t row;
    row = '0;
    row.item.mode = wsvs_pkg::MODE_TICK;
    row.typed = 1'b1;
    row.want = '{dac, step, advanced};
    demo_rows.push_back(row);
  endtask

  task automatic add_reg(wsvs_pkg::cfg_index_t idx, logic [31:0] v);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    demo_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      results_seen++;
      if (pending_samples.size() == 0) begin
        log_error($sformatf("sample %h with none pending", m_tdata));
      end else begin
        got_expect = pending_samples.pop_front();
        if (m_tdata[11:0] !== got_expect.dac)
          log_error($sformatf("dac_code exp %h got %h", got_expect.dac, m_tdata[11:0]));
        if (m_tdata[15:12] !== got_expect.step)
          log_error($sformatf("active_step exp %0d got %0d", got_expect.step, m_tdata[15:12]));
        if (m_tdata[16] !== got_expect.advanced)
          log_error($sformatf("step_advanced exp %b got %b", got_expect.advanced, m_tdata[16]));
      end
    end
  end

  // output side, with one long hold-off so the input backs up
  initial begin
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 130) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      m_tready <= (calm || $urandom_range(99) >= 17);
    end
  end

  initial begin
    // idle voice: every sample silent, step still
    add_typed_tick(12'd0, 4'd0, 1'b0);
    add_item(wsvs_pkg::MODE_WAVE, 15'd18431, wsvs_pkg::FULL_SCALE, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_WAVE, 15'd18432, 32'h1234_5678, 6'd63, 1'b1);
    add_item(wsvs_pkg::MODE_WAVE, 15'h7FFF, wsvs_pkg::FULL_SCALE, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_PITCH, 15'd63, wsvs_pkg::FULL_SCALE, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_PITCH, 15'd64, 32'd0, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_PITCH, 15'h7FFF, 32'd0, 6'd63, 1'b1);
    add_item(wsvs_pkg::MODE_STEP, 15'd15, 32'd0, 6'd48, 1'b1);
    add_item(wsvs_pkg::MODE_STEP, 15'd16, 32'd0, 6'd63, 1'b1);
    add_item(wsvs_pkg::MODE_STEP, 15'h7FFF, wsvs_pkg::FULL_SCALE, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_STEP, 15'd1, 32'd0, 6'd63, 1'b1);
    add_item(wsvs_pkg::MODE_STEP, 15'd2, 32'd0, 6'd0, 1'b1);
    // one step per sample, amp still at zero
    add_reg(wsvs_pkg::CFG_TEMPO_INCREMENT, 32'h1000_0000);
    add_typed_tick(12'd0, 4'd1, 1'b1);
    add_typed_tick(12'd0, 4'd2, 1'b1);
    // full-scale attack, blend clamped and saturated, table select masked
    add_reg(wsvs_pkg::CFG_AMP_RISE_STEP, wsvs_pkg::FULL_SCALE);
    add_reg(wsvs_pkg::CFG_SHAPE_RISE_STEP, wsvs_pkg::FULL_SCALE);
    add_reg(wsvs_pkg::CFG_AMP_FALL_STEP, 32'h0100_0000);
    add_reg(wsvs_pkg::CFG_SHAPE_FALL_STEP, 32'h0080_0000);
    add_reg(wsvs_pkg::CFG_SHAPE_AMOUNT, wsvs_pkg::FULL_SCALE);
    add_reg(wsvs_pkg::CFG_BLEND_POSITION, wsvs_pkg::FULL_SCALE);
    add_reg(wsvs_pkg::CFG_TABLE_SELECT, wsvs_pkg::FULL_SCALE);
    add_item(wsvs_pkg::MODE_TICK, 15'h7FFF, wsvs_pkg::FULL_SCALE, 6'd63, 1'b1);
    add_item(wsvs_pkg::MODE_TICK, 15'd0, 32'd0, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_TICK, 15'h2AAA, 32'h5555_5555, 6'd21, 1'b1);
    add_item(wsvs_pkg::MODE_TICK, 15'h5555, 32'hAAAA_AAAA, 6'd42, 1'b0);
    // sequencer paused, fast release
    add_reg(wsvs_pkg::CFG_BLEND_POSITION, 32'hC000_0000);
    add_reg(wsvs_pkg::CFG_SHAPE_AMOUNT, 32'h0000_0080);
    add_reg(wsvs_pkg::CFG_TABLE_SELECT, 32'd1);
    add_reg(wsvs_pkg::CFG_TEMPO_INCREMENT, 32'd0);
    add_reg(wsvs_pkg::CFG_AMP_FALL_STEP, wsvs_pkg::FULL_SCALE);
    add_item(wsvs_pkg::MODE_TICK, 15'd0, 32'd0, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_WAVE, 15'd0, 32'd0, 6'd0, 1'b0);
    add_item(wsvs_pkg::MODE_TICK, 15'h7FFF, wsvs_pkg::FULL_SCALE, 6'd63, 1'b1);
    add_item(wsvs_pkg::MODE_TICK, 15'd0, 32'd0, 6'd0, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (demo_rows[r]) begin
      if (demo_rows[r].is_reg) begin
        drain_voice();
        set_register(demo_rows[r].reg_idx, demo_rows[r].reg_val);
      end else begin
        play(demo_rows[r].item, demo_rows[r].typed, demo_rows[r].want);
      end
    end

    // random phases: mixed settings, then all max, all zero, then mixed settings again
    for (int ph = 0; ph < 7; ph++) begin
      drain_voice();
      for (int k = 0; k < 8; k++)
        set_register(wsvs_pkg::cfg_index_t'(k),
                     pick_register_value(wsvs_pkg::cfg_index_t'(k),
                                         (ph == 1) ? 1 : ((ph == 2) ? 0 : 2)));
      calm = (ph == 4);
      repeat (90) play(random_item(), 1'b0, '0);
    end
    calm = 1'b0;

    drain_voice();
    repeat (10) @(posedge clk);
    $display("voice run: %0d items (%0d ticks, %0d store writes), %0d register writes",
             items_sent, ticks_sent, items_sent - ticks_sent, reg_writes);
    $display("%0d samples compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[wavetable_synth_voice_sequencer_unit.f]
src/wsvs_pkg.sv
src/wsvs_ram.sv
src/wsvs_step_mem.sv
src/wavetable_synth_voice_sequencer_unit.sv
test/wavetable_synth_voice_sequencer_unit_tb.sv
